/* src/bptb_pkg.sv */
// Package with shared types and constants for the button press timer blinker.
package bptb_pkg;

   localparam int OUT_BUTTONS = 4;
   localparam int CNT_W       = 24;
   localparam int MS_W        = 20;
   localparam int TPM_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int LED_W       = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [MS_W-1:0]  MS_MAX  = {MS_W{1'b1}};
   localparam logic [LED_W-1:0] LED_ALL = {LED_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_PER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_MS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LOW = 3'd4;

   localparam logic [CNT_W-1:0] RST_DEBOUNCE  = 24'd200000;
   localparam logic [CNT_W-1:0] RST_BLINK_PER = 24'd2500000;
   localparam logic [TPM_W-1:0] RST_TICKS_MS  = 16'd10000;
   localparam logic [MS_W-1:0]  RST_LONG_MS   = 20'd1000;

   typedef struct packed {
      logic [CNT_W-1:0] settle_limit;
      logic [CNT_W-1:0] toggle_period;
      logic [TPM_W-1:0] ms_divisor;
      logic [MS_W-1:0]  long_press_ms;
      logic             buttons_active_low;
   } cfg_type;

   typedef struct packed {
      logic            press;
      logic            release_hit;
      logic            long_hit;
      logic [MS_W-1:0] ms;
   } lane_evt_type;

endpackage

/* src/bptb_if.sv */
// Request and response channel interfaces.
interface bptb_req_if;
   import bptb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OUT_BUTTONS-1:0]     buttons_raw;
   modport source (output valid, output buttons_raw, input ready);
   modport sink (input valid, input buttons_raw, output ready);
endinterface

interface bptb_rsp_if;
   import bptb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LED_W-1:0]       led_pattern;
   logic                   blinking;
   logic [OUT_BUTTONS-1:0] release_mask;
   logic [MS_W-1:0]        button0_ms;
   logic [MS_W-1:0]        button1_ms;
   logic [MS_W-1:0]        button2_ms;
   logic [MS_W-1:0]        button3_ms;
   modport source (output valid, output led_pattern, output blinking, output release_mask,
                   output button0_ms, output button1_ms, output button2_ms,
                   output button3_ms, input ready);
   modport sink (input valid, input led_pattern, input blinking, input release_mask,
                 input button0_ms, input button1_ms, input button2_ms,
                 input button3_ms, output ready);
endinterface

/* src/button_press_timer_blinker.sv */
// Top level of the debounced button press timer with long-press LED blinker.
//
//   port     dir  handshake      contents
//   req_if   in   valid/ready    buttons_raw, one timebase tick per request
//   rsp_if   out  valid/ready    led_pattern, blinking, release_mask, button0..3_ms
//   csr_*    in   csr_we         csr_index, csr_wdata, write only
//
// One request per clock while the response is not stalled; its response is registered and shows in the next cycle.
// All button lanes and the blink merge evaluate a request combinationally, in the cycle it is accepted.
// A new request is taken while the response register is empty or being drained.
// Synchronous active-high reset clears all lane and blinker state and reloads
// the register defaults.
module button_press_timer_blinker
   import bptb_pkg::*;
#(
   parameter int BUTTONS = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   bptb_req_if.sink              req_if,
   bptb_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int OWNER_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   cfg_type            cfg_ff;
   logic               advance;
   logic               rsp_valid_ff;
   lane_evt_type       evt [BUTTONS];
   logic [LED_W-1:0]   led_next;
   logic               blink_next;
   logic [OUT_BUTTONS-1:0] mask_in, mask_ff;
   logic [MS_W-1:0]    dur_in [OUT_BUTTONS];
   logic [MS_W-1:0]    dur_ff [OUT_BUTTONS];
   logic [LED_W-1:0]   led_ff;
   logic               blink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_limit       <= RST_DEBOUNCE;
         cfg_ff.toggle_period      <= RST_BLINK_PER;
         cfg_ff.ms_divisor         <= RST_TICKS_MS;
         cfg_ff.long_press_ms      <= RST_LONG_MS;
         cfg_ff.buttons_active_low <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE:   cfg_ff.settle_limit       <= csr_wdata[CNT_W-1:0];
            REG_BLINK_PER:  cfg_ff.toggle_period      <= csr_wdata[CNT_W-1:0];
            REG_TICKS_MS:   cfg_ff.ms_divisor         <= csr_wdata[TPM_W-1:0];
            REG_LONG_MS:    cfg_ff.long_press_ms      <= csr_wdata[MS_W-1:0];
            REG_ACTIVE_LOW: cfg_ff.buttons_active_low <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign advance      = req_if.valid && req_if.ready;

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      logic raw;
      if (g < OUT_BUTTONS) begin : g_pin
         assign raw = req_if.buttons_raw[g] ^ cfg_ff.buttons_active_low;
      end else begin : g_nopin
         assign raw = 1'b0;
      end
      bptb_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .raw     (raw),
         .cfg     (cfg_ff),
         .evt     (evt[g])
      );
   end

   bptb_blink #(
      .BUTTONS (BUTTONS),
      .OWNER_W (OWNER_W)
   ) u_blink (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .evt           (evt),
      .toggle_period (cfg_ff.toggle_period),
      .led_next      (led_next),
      .blink_next    (blink_next)
   );

   for (genvar j = 0; j < OUT_BUTTONS; j++) begin : g_out
      if (j < BUTTONS) begin : g_used
         assign mask_in[j] = evt[j].release_hit;
         assign dur_in[j]  = evt[j].release_hit ? evt[j].ms : '0;
      end else begin : g_unused
         assign mask_in[j] = 1'b0;
         assign dur_in[j]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_ff   <= led_next;
         blink_ff <= blink_next;
         mask_ff  <= mask_in;
         dur_ff   <= dur_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.led_pattern  = led_ff;
   assign rsp_if.blinking     = blink_ff;
   assign rsp_if.release_mask = mask_ff;
   assign rsp_if.button0_ms   = dur_ff[0];
   assign rsp_if.button1_ms   = dur_ff[1];
   assign rsp_if.button2_ms   = dur_ff[2];
   assign rsp_if.button3_ms   = dur_ff[3];

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_if.valid)
      else $error("accepted request produced no response");

   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.blinking) |-> (rsp_if.led_pattern == '0))
      else $error("LEDs lit outside blink mode");

   a_dur_zero_b0: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.release_mask[0]) |-> (rsp_if.button0_ms == '0))
      else $error("button 0 duration without release");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> $stable(led_ff) && $stable(mask_ff))
      else $error("stalled response changed");

endmodule

/* src/bptb_lane.sv */
// One button lane: debounce filter and press duration counter.
module bptb_lane
   import bptb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          raw,
   input  cfg_type       cfg,
   output lane_evt_type  evt
);

   logic              prev_ff, prev_in;
   logic              stable_ff, stable_in;
   logic [CNT_W-1:0]  settle_ff, settle_in;
   logic              meas_ff, meas_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic [TPM_W-1:0]  sub_ff, sub_in;

   logic [TPM_W-1:0]  tpm;
   logic [TPM_W-1:0]  sub_inc;
   logic              ms_step;
   logic [MS_W-1:0]   ms_cur;
   logic [TPM_W-1:0]  sub_cur;
   logic              change;

   always_comb begin
      tpm     = (cfg.ms_divisor == '0) ? TPM_W'(1) : cfg.ms_divisor;
      sub_inc = sub_ff + TPM_W'(1);
      ms_step = meas_ff && (sub_inc >= tpm);
      ms_cur  = (ms_step && ms_ff != MS_MAX) ? ms_ff + MS_W'(1) : ms_ff;
      if (meas_ff) begin
         sub_cur = (sub_inc >= tpm) ? '0 : sub_inc;
      end else begin
         sub_cur = sub_ff;
      end

      prev_in = raw;
      if (raw != prev_ff) begin
         settle_in = '0;
      end else begin
         settle_in = (settle_ff == CNT_MAX) ? settle_ff : settle_ff + CNT_W'(1);
      end

      change    = (settle_in >= cfg.settle_limit) && (raw != stable_ff);
      stable_in = change ? raw : stable_ff;
      meas_in   = meas_ff;
      ms_in     = ms_cur;
      sub_in    = sub_cur;
      if (change && raw) begin
         meas_in = 1'b1;
         ms_in   = '0;
         sub_in  = '0;
      end else if (change && meas_ff) begin
         meas_in = 1'b0;
      end

      evt.press       = change && raw;
      evt.release_hit = change && !raw && meas_ff;
      evt.long_hit    = ms_cur >= cfg.long_press_ms;
      evt.ms          = ms_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b0;
         stable_ff <= 1'b0;
         settle_ff <= '0;
         meas_ff   <= 1'b0;
         ms_ff     <= '0;
         sub_ff    <= '0;
      end else if (advance) begin
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
         settle_ff <= settle_in;
         meas_ff   <= meas_in;
         ms_ff     <= ms_in;
         sub_ff    <= sub_in;
      end
   end

endmodule

/* src/bptb_blink.sv */
// Merge stage: combines lane events in button order and runs the LED blinker.
module bptb_blink
   import bptb_pkg::*;
#(
   parameter int BUTTONS = 4,
   parameter int OWNER_W = 2
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lane_evt_type      evt [BUTTONS],
   input  logic [CNT_W-1:0]  toggle_period,
   output logic [LED_W-1:0]  led_next,
   output logic              blink_next
);

   logic               on_ff, on_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LED_W-1:0]   led_ff, led_in;

   always_comb begin
      on_in    = on_ff;
      owner_in = owner_ff;
      led_in   = led_ff;
      if (on_ff) begin
         cnt_in = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      for (int i = 0; i < BUTTONS; i++) begin
         if (evt[i].press && on_in && OWNER_W'(i) != owner_in) begin
            on_in  = 1'b0;
            led_in = '0;
         end
         if (evt[i].release_hit && evt[i].long_hit) begin
            on_in    = 1'b1;
            led_in   = LED_ALL;
            owner_in = OWNER_W'(i);
            cnt_in   = '0;
         end
      end
      if (on_in && cnt_in >= toggle_period) begin
         cnt_in = '0;
         led_in = ~led_in;
      end
      led_next   = led_in;
      blink_next = on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         owner_ff <= '0;
         cnt_ff   <= '0;
         led_ff   <= '0;
      end else if (advance) begin
         on_ff    <= on_in;
         owner_ff <= owner_in;
         cnt_ff   <= cnt_in;
         led_ff   <= led_in;
      end
   end

endmodule

/* dv/tb_button_press_timer_blinker.sv */
// Testbench for the button press timer blinker: a predictor-backed scoreboard checking every tick.
`timescale 1ns / 1ps

module tb_button_press_timer_blinker;
   import bptb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int LONG_HOLD_TICKS = 60;

   typedef struct packed {
      logic [LED_W-1:0]                  led_pattern;
      logic                              blinking;
      logic [OUT_BUTTONS-1:0]            release_mask;
      logic [OUT_BUTTONS-1:0][MS_W-1:0]  ms;
   } tick_result_type;

   class scoreboard_type;
      cfg_type              cfg;
      bit [OUT_BUTTONS-1:0] prev_raw;
      bit [OUT_BUTTONS-1:0] stable;
      bit [OUT_BUTTONS-1:0] measuring;
      int unsigned          settle [OUT_BUTTONS];
      int unsigned          press_ms [OUT_BUTTONS];
      int unsigned          sub_ms [OUT_BUTTONS];
      bit                   blink_on;
      int unsigned          blink_owner;
      int unsigned          blink_count;
      logic [LED_W-1:0]     led_bits;
      tick_result_type      expected_ticks [$];
      int unsigned          errors;

      function new();
         cfg.settle_limit       = RST_DEBOUNCE;
         cfg.toggle_period      = RST_BLINK_PER;
         cfg.ms_divisor         = RST_TICKS_MS;
         cfg.long_press_ms      = RST_LONG_MS;
         cfg.buttons_active_low = 1'b0;
         prev_raw    = '0;
         stable      = '0;
         measuring   = '0;
         for (int i = 0; i < OUT_BUTTONS; i++) begin
            settle[i]   = 0;
            press_ms[i] = 0;
            sub_ms[i]   = 0;
         end
         blink_on    = 1'b0;
         blink_owner = 0;
         blink_count = 0;
         led_bits    = '0;
         errors      = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_DEBOUNCE:   cfg.settle_limit       = val[CNT_W-1:0];
            REG_BLINK_PER:  cfg.toggle_period      = val[CNT_W-1:0];
            REG_TICKS_MS:   cfg.ms_divisor         = val[TPM_W-1:0];
            REG_LONG_MS:    cfg.long_press_ms      = val[MS_W-1:0];
            REG_ACTIVE_LOW: cfg.buttons_active_low = val[0];
            default: ;
         endcase
      endfunction

      function int unsigned sat_cnt(int unsigned v);
         return (v >= CNT_MAX) ? CNT_MAX : v + 1;
      endfunction

      function tick_result_type predict_tick(logic [OUT_BUTTONS-1:0] raw_in);
         tick_result_type r;
         int unsigned     tpm;
         bit              lvl;
         r   = '0;
         tpm = (cfg.ms_divisor == 0) ? 1 : cfg.ms_divisor;
         if (blink_on) blink_count = sat_cnt(blink_count);
         for (int unsigned i = 0; i < OUT_BUTTONS; i++) begin
            lvl = raw_in[i] ^ cfg.buttons_active_low;
            if (measuring[i]) begin
               sub_ms[i]++;
               if (sub_ms[i] >= tpm) begin
                  sub_ms[i] = 0;
                  if (press_ms[i] < MS_MAX) press_ms[i]++;
               end
            end
            if (lvl != prev_raw[i]) begin
               prev_raw[i] = lvl;
               settle[i]   = 0;
            end else begin
               settle[i] = sat_cnt(settle[i]);
            end
            if (settle[i] >= cfg.settle_limit && lvl != stable[i]) begin
               stable[i] = lvl;
               if (lvl) begin
                  measuring[i] = 1'b1;
                  press_ms[i]  = 0;
                  sub_ms[i]    = 0;
                  // press of a non-owner cancels blinking
                  if (blink_on && i != blink_owner) begin
                     blink_on = 1'b0;
                     led_bits = '0;
                  end
               end else if (measuring[i]) begin
                  measuring[i]      = 1'b0;
                  r.release_mask[i] = 1'b1;
                  r.ms[i]           = MS_W'(press_ms[i]);
                  if (press_ms[i] >= cfg.long_press_ms) begin
                     led_bits    = LED_ALL;
                     blink_on    = 1'b1;
                     blink_owner = i;
                     blink_count = 0;
                  end
               end
            end
         end
         if (blink_on && blink_count >= cfg.toggle_period) begin
            blink_count = 0;
            led_bits    = ~led_bits;
         end
         r.led_pattern = led_bits;
         r.blinking    = blink_on;
         return r;
      endfunction

      function void note_request(logic [OUT_BUTTONS-1:0] raw_in);
         expected_ticks.push_back(predict_tick(raw_in));
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(tick_result_type got);
         tick_result_type exp;
         if (expected_ticks.size() == 0) begin
            report("response with no outstanding request");
            return;
         end
         exp = expected_ticks.pop_front();
         if (got.led_pattern !== exp.led_pattern)
            report($sformatf("led_pattern got %h exp %h", got.led_pattern, exp.led_pattern));
         if (got.blinking !== exp.blinking)
            report($sformatf("blinking got %b exp %b", got.blinking, exp.blinking));
         if (got.release_mask !== exp.release_mask)
            report($sformatf("release_mask got %h exp %h", got.release_mask, exp.release_mask));
         for (int i = 0; i < OUT_BUTTONS; i++) begin
            if (got.ms[i] !== exp.ms[i])
               report($sformatf("button%0d_ms got %0d exp %0d", i, got.ms[i], exp.ms[i]));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    idle_en = 1'b1;
   logic [OUT_BUTTONS-1:0] held_levels = '0;
   int unsigned           quiet_cycles = 0;

   scoreboard_type sb = new();

   bptb_req_if req_if ();
   bptb_rsp_if rsp_if ();

   button_press_timer_blinker #(.BUTTONS(4)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !idle_en || ($urandom_range(0, 99) >= 7);
      end
   end

   always @(posedge clock) begin : monitor
      tick_result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_request(req_if.buttons_raw);
         if (rsp_if.valid && rsp_if.ready) begin
            got.led_pattern  = rsp_if.led_pattern;
            got.blinking     = rsp_if.blinking;
            got.release_mask = rsp_if.release_mask;
            got.ms[0]        = rsp_if.button0_ms;
            got.ms[1]        = rsp_if.button1_ms;
            got.ms[2]        = rsp_if.button2_ms;
            got.ms[3]        = rsp_if.button3_ms;
            sb.check_response(got);
         end
      end
      if (reset || csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_button_press_timer_blinker: FAIL");
         $finish;
      end
   end

   // returns in the step of the accepting edge, valid still high
   task automatic send_tick(input logic [OUT_BUTTONS-1:0] levels);
      while (idle_en && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.buttons_raw <= levels;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_repeat(input logic [OUT_BUTTONS-1:0] levels, input int n);
      for (int k = 0; k < n; k++) send_tick(levels);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.configure(idx, val);
   endtask

   task automatic load_config(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] blink,
                              input logic [TPM_W-1:0] tpm, input logic [MS_W-1:0] long_ms,
                              input logic active_low);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      write_reg(REG_DEBOUNCE, CSR_DATA_W'(deb));
      write_reg(REG_BLINK_PER, CSR_DATA_W'(blink));
      write_reg(REG_TICKS_MS, CSR_DATA_W'(tpm));
      write_reg(REG_LONG_MS, CSR_DATA_W'(long_ms));
      write_reg(REG_ACTIVE_LOW, CSR_DATA_W'(active_low));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      logic [CNT_W-1:0] deb;
      logic [CNT_W-1:0] blink;
      logic [TPM_W-1:0] tpm;
      logic [MS_W-1:0]  long_ms;
      int unsigned      r;
      deb   = ($urandom_range(0, 99) < 10) ? CNT_MAX : CNT_W'($urandom_range(0, 4));
      blink = ($urandom_range(0, 99) < 10) ? CNT_MAX : CNT_W'($urandom_range(0, 6));
      r = $urandom_range(0, 99);
      if (r < 10)      tpm = {TPM_W{1'b1}};
      else if (r < 20) tpm = '0;
      else             tpm = TPM_W'($urandom_range(1, 3));
      long_ms = ($urandom_range(0, 99) < 10) ? MS_MAX : MS_W'($urandom_range(0, 5));
      load_config(deb, blink, tpm, long_ms, 1'($urandom_range(0, 1)));
   endtask

   // buttons hold levels for runs of ticks, with occasional one-tick glitches
   task automatic random_phase(input int n);
      logic [OUT_BUTTONS-1:0] glitch;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < OUT_BUTTONS; i++) begin
            if ($urandom_range(0, 7) == 0) held_levels[i] = ~held_levels[i];
            glitch[i] = ($urandom_range(0, 19) == 0);
         end
         send_tick(held_levels ^ glitch);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.buttons_raw <= '0;
      csr_we             <= 1'b0;
      csr_index          <= REG_DEBOUNCE;
      csr_wdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing settles this early
      send_tick(4'hF);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'h5);
      send_tick(4'hA);

      // zero debounce and blink period, long press then cancel by another button
      load_config('0, '0, 16'd1, 20'd2, 1'b0);
      send_repeat(4'h1, 4);
      send_repeat(4'h0, 3);
      send_tick(4'h2);
      send_tick(4'h0);
      send_repeat(4'h8, 3);
      send_tick(4'h0);

      // inverted levels, zero ticks per ms, zero long press
      load_config(24'd1, 24'd1, '0, '0, 1'b1);
      send_repeat(4'hF, 2);
      send_repeat(4'h0, 3);
      send_repeat(4'hF, 3);

      // long hold under the maximum long-press limit, no idling on either side
      load_config('0, 24'd2, 16'd1, MS_MAX, 1'b0);
      idle_en = 1'b0;
      send_repeat(4'h4, LONG_HOLD_TICKS);
      send_repeat(4'h0, 4);
      idle_en = 1'b1;

      for (int p = 0; p < 12; p++) begin
         random_config();
         random_phase(26);
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_button_press_timer_blinker: PASS");
      else
         $display("tb_button_press_timer_blinker: FAIL");
      $finish;
   end

endmodule
